/* hw/rtl/wpp_pkg.sv */
// Shared types and constants for the windowed peak picker.
// Used by the controller, the datapath and the top level; no dependencies.

package wpp_pkg;

   localparam int MAX_HALF_DEF   = 31;
   localparam int INDEX_BITS_DEF = 16;
   localparam int SAMPLE_W       = 16;
   localparam int POS_W          = 16;
   localparam int HALF_W         = 5;
   localparam int CSR_IDX_W      = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_WINDOW = 1'd1;

   typedef struct packed {
      logic accept;
      logic rd_cand;
      logic cand_load;
      logic scan_adv;
      logic cmp_en;
      logic emit;
      logic d_dec;
      logic clear;
   } wpp_cmd_type;

   typedef struct packed {
      logic last;
      logic d_valid;
      logic d_zero;
      logic scan_done;
      logic out_free;
   } wpp_stat_type;

endpackage

/* hw/rtl/windowed_peak_picker_core.sv */
// Windowed peak picker: one sample in, verdicts for thresholded local maxima out.
// A new sample is accepted only when idle; a non-final item yields at most one verdict,
// on slot H, from a one-read-per-cycle scan of the sample ring memory.
// A final item walks every slot from H down to 0, and output stalls can hold it.
// Synchronous active-high reset clears control, the window and the config to 0, H=1.

module windowed_peak_picker_core
   import wpp_pkg::*;
#(
   parameter int MAX_HALF   = MAX_HALF_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // [15:0] sample
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [15:0] position
   output logic                 rsp_tuser,   // [0] is_peak
   output logic                 rsp_tlast,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]          csr_data
);

   wpp_cmd_type  cmd;
   wpp_stat_type stat;

   assign csr_ready = 1'b1;

   wpp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wpp_datapath #(
      .MAX_HALF   (MAX_HALF),
      .INDEX_BITS (INDEX_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_sample   (req_tdata),
      .req_last     (req_tlast),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_position (rsp_tdata),
      .rsp_is_peak  (rsp_tuser),
      .rsp_last_res (rsp_tlast)
   );

endmodule

/* hw/rtl/wpp_ctrl.sv */
// Sequencer for the windowed peak picker: accepts a sample, then walks the
// verdict slots and scans each window. Depends on wpp_pkg.

module wpp_ctrl
   import wpp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  wpp_stat_type stat,
   output wpp_cmd_type  cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_CAND  = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_DRAIN = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.d_valid) begin
               cmd.rd_cand = 1'b1;
               state_in    = ST_CAND;
            end else if (stat.last && !stat.d_zero) begin
               cmd.d_dec = 1'b1;
            end else begin
               cmd.clear = stat.last;
               state_in  = ST_IDLE;
            end
         end
         ST_CAND: begin
            cmd.cand_load = 1'b1;
            cmd.scan_adv  = 1'b1;
            state_in      = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.cmp_en   = 1'b1;
            cmd.scan_adv = 1'b1;
            if (stat.scan_done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            cmd.cmp_en = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               if (stat.last && !stat.d_zero) begin
                  cmd.d_dec = 1'b1;
                  state_in  = ST_CHECK;
               end else begin
                  cmd.clear = stat.last;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hw/rtl/wpp_datapath.sv */
// Datapath of the windowed peak picker: sample ring memory, valid shift line,
// position counter, window compare and the result register. Depends on wpp_pkg.

module wpp_datapath
   import wpp_pkg::*;
#(
   parameter int MAX_HALF   = MAX_HALF_DEF,
   parameter int INDEX_BITS = INDEX_BITS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  wpp_cmd_type                 cmd,
   output wpp_stat_type                stat,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_last,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [SAMPLE_W-1:0]         csr_data,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [POS_W-1:0]            rsp_position,
   output logic                        rsp_is_peak,
   output logic                        rsp_last_res
);

   localparam int DEPTH = 2 * MAX_HALF + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int SW    = (AW > HALF_W) ? AW : HALF_W;

   logic signed [SAMPLE_W-1:0] threshold_ff;
   logic [HALF_W-1:0]          half_ff;
   logic [SW-1:0]              half_clamp;
   logic [AW-1:0]              eff_h;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_vld_ff;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [AW-1:0]              rd_slot, rd_addr;
   logic [AW:0]                wrap_sum;
   logic [DEPTH-1:0]           valid_ff;

   logic [INDEX_BITS-1:0]      cnt_ff;
   logic [INDEX_BITS-1:0]      newest_ff;
   logic [INDEX_BITS+15:0]     newest_ext;
   logic                       last_ff;
   logic [AW-1:0]              d_ff;
   logic [AW-1:0]              scan_ff;
   logic signed [SAMPLE_W-1:0] cand_ff;
   logic                       fail_ff;

   logic                       rsp_valid_ff;
   logic [POS_W-1:0]           rsp_pos_ff;
   logic                       rsp_peak_ff;
   logic                       rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         half_ff      <= HALF_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_THRESHOLD:   threshold_ff <= csr_data;
            CSR_HALF_WINDOW: half_ff      <= csr_data[HALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      half_clamp = SW'(half_ff);
      if (half_clamp == '0) begin
         half_clamp = SW'(1);
      end else if (half_clamp > SW'(MAX_HALF)) begin
         half_clamp = SW'(MAX_HALF);
      end
      eff_h = AW'(half_clamp);
   end

   assign wp_in    = (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1;
   assign rd_slot  = cmd.rd_cand ? d_ff : scan_ff;
   assign wrap_sum = {1'b0, wp_ff} + (AW+1)'(DEPTH) - {1'b0, rd_slot};
   assign rd_addr  = (wp_ff >= rd_slot) ? (wp_ff - rd_slot) : AW'(wrap_sum);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mem[wp_in] <= req_sample;
      end
      rd_data_ff <= mem[rd_addr];
      rd_vld_ff  <= valid_ff[rd_slot];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         valid_ff <= '0;
         cnt_ff   <= '0;
      end else if (cmd.accept) begin
         wp_ff    <= wp_in;
         valid_ff <= {valid_ff[DEPTH-2:0], 1'b1};
         if (req_last) begin
            cnt_ff <= '0;
         end else if (cnt_ff != '1) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end else if (cmd.clear) begin
         valid_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         newest_ff <= cnt_ff;
         last_ff   <= req_last;
         d_ff      <= eff_h;
      end else if (cmd.d_dec) begin
         d_ff <= d_ff - 1'b1;
      end
      if (cmd.rd_cand) begin
         scan_ff <= '0;
      end else if (cmd.scan_adv) begin
         scan_ff <= scan_ff + 1'b1;
      end
      if (cmd.cand_load) begin
         cand_ff <= rd_data_ff;
         fail_ff <= (rd_data_ff < threshold_ff);
      end else if (cmd.cmp_en) begin
         fail_ff <= fail_ff | (rd_vld_ff && (rd_data_ff > cand_ff));
      end
   end

   assign newest_ext = {16'b0, newest_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_pos_ff  <= newest_ext[15:0] - POS_W'(d_ff);
         rsp_peak_ff <= !fail_ff;
         rsp_last_ff <= last_ff && (d_ff == '0);
      end
   end

   assign stat.last      = last_ff;
   assign stat.d_valid   = valid_ff[d_ff];
   assign stat.d_zero    = (d_ff == '0);
   assign stat.scan_done = (scan_ff == d_ff + eff_h);
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_is_peak  = rsp_peak_ff;
   assign rsp_last_res = rsp_last_ff;

endmodule

/* hw/rtl/wpp_checker.sv */
// Port-level checks for windowed_peak_picker_core, bound to the top level.
// Depends on wpp_pkg.

module wpp_checker
   import wpp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tvalid,
   input logic                 req_tready,
   input logic [15:0]          req_tdata,
   input logic                 req_tlast,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [15:0]          rsp_tdata,
   input logic                 rsp_tuser,
   input logic                 rsp_tlast,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [15:0]          csr_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while a sample is in work");

   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared while idle");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("outputs not quiet after reset");

endmodule

bind windowed_peak_picker_core wpp_checker u_wpp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast),
   .csr_valid  (csr_valid),
   .csr_ready  (csr_ready),
   .csr_index  (csr_index),
   .csr_data   (csr_data)
);
